### rtl/grb_pkg.sv
// Package: payload types, fixed-point constants and the quarter-wave sine table.
package grb_pkg;

  localparam int POS_FRAC_BITS  = 8;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int POS_W          = 22;
  localparam int CELL_W         = 13;
  localparam int LIM_W          = 14;
  localparam int MAG_W          = TRIG_FRAC_BITS + 1;
  localparam int QUARTER        = 1440;
  localparam int HALF_TURN      = 2880;
  localparam int FULL_TURN      = 5760;
  localparam int CELL_RESET     = 100;
  localparam int LIMIT_RESET    = 10000;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic REG_CELL  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [12:0]       yaw;
    logic signed [11:0] pitch;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] next_x;
    logic [POS_W-1:0] next_y;
    logic [POS_W-1:0] next_z;
    logic [1:0]       crossed_axis;
    logic             inside_world;
  } out_t;

  typedef logic [MAG_W-1:0] sine_tab_t [0:QUARTER];

  // Taylor series in Q30, nine terms, each truncated; clamped, then rounded.
  // Term k divides by (2k)(2k+1): 6, 20, 42, 72, 110, 156, 210, 272.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned s;
    x    = (longint'(q) * PI_Q30 + 64'd1440) / 64'd2880;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    if (sum < 0)       sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    s = longint'(sum);
    s = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return MAG_W'(s);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int i = 0; i <= QUARTER; i++) t[i] = quarter_sine(i);
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

### rtl/grb_div.sv
// Pipelined restoring divider, two quotient bits per stage, with a sideband.
module grb_div
  import grb_pkg::*;
#(
  parameter int NW = 14,
  parameter int DW = 13,
  parameter int QW = 14,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [NW-1:0] rem_out,
  output logic [SW-1:0] side_out
);

  localparam int NS = (QW + 1) / 2;
  localparam int WW = NW + QW + DW;

  logic          vld [NS];
  logic [NW-1:0] rm  [NS];
  logic [QW-1:0] qt  [NS];
  logic [DW-1:0] dn  [NS];
  logic [SW-1:0] sd  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          src_v;
    logic [NW-1:0] src_r;
    logic [QW-1:0] src_q;
    logic [DW-1:0] src_d;
    logic [SW-1:0] src_s;
    logic [WW-1:0] r0;
    logic [QW-1:0] qa;

    if (k == 0) begin : g_first
      assign src_v = in_valid;
      assign src_r = num;
      assign src_q = '0;
      assign src_d = den;
      assign src_s = side_in;
    end else begin : g_next
      assign src_v = vld[k-1];
      assign src_r = rm[k-1];
      assign src_q = qt[k-1];
      assign src_d = dn[k-1];
      assign src_s = sd[k-1];
    end

    always_comb begin
      int b;
      r0 = WW'(src_r);
      qa = src_q;
      for (int j = 0; j < 2; j++) begin
        b = QW - 1 - 2 * k - j;
        if (b >= 0) begin
          if (r0 >= (WW'(src_d) << b)) begin
            r0    = r0 - (WW'(src_d) << b);
            qa[b] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_v;
      end
      if (en) begin
        rm[k] <= NW'(r0);
        qt[k] <= qa;
        dn[k] <= src_d;
        sd[k] <= src_s;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign quo       = qt[NS-1];
  assign rem_out   = rm[NS-1];
  assign side_out  = sd[NS-1];

endmodule

### rtl/grid_ray_next_boundary_top.sv
// Top level: one grid ray step to the nearest cell plane, fully pipelined.
// Pipeline: 26 register stages (input reg, ROM read, 7-stage remainder
// divider, four compare and offset stages, 12-stage offset divider, output reg).
// Throughput: one item per cycle; a stall at the output freezes every stage.
// Reset (rst, synchronous): stage valids clear, cell_size 100, world_limit 10000.
module grid_ray_next_boundary_top
  import grb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int INT_W  = POS_W - POS_FRAC_BITS;   // whole-unit part of a position
  localparam int CQ_W   = CELL_W + POS_FRAC_BITS;  // cell edge in position units
  localparam int PROD_W = CQ_W + MAG_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int OFF_W  = POS_W + 1;
  localparam int NC_W   = OFF_W + 2;
  localparam int S1_W   = MAG_W + 1 + POS_W;
  localparam int S2_W   = 2 + 1 + 1 + POS_W;

  typedef struct packed {
    logic [10:0] q;
    logic        neg;
  } ang_t;

  // ---------------- configuration registers ----------------
  logic [CELL_W-1:0] cell_size;
  logic [LIM_W-1:0]  world_limit;
  logic [CELL_W-1:0] cell_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size   <= CELL_W'(CELL_RESET);
      world_limit <= LIM_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_CELL:  cell_size   <= pwdata[CELL_W-1:0];
        REG_LIMIT: world_limit <= pwdata[LIM_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CELL:  prdata = 32'(cell_size);
      REG_LIMIT: prdata = 32'(world_limit);
      default:   prdata = '0;
    endcase
  end

  // cell size zero behaves as one
  assign cell_eff = (cell_size == '0) ? CELL_W'(1) : cell_size;

  // ---------------- global stall ----------------
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage A: input register ----------------
  logic a_v;
  in_t  a_d;

  always_ff @(posedge clk) begin
    if (rst)      a_v <= 1'b0;
    else if (adv) a_v <= in_valid;
    if (adv) a_d <= in_data;
  end

  // fold an angle in [0, 5760) onto the quarter wave
  function automatic ang_t map_angle(input logic [13:0] a);
    logic [12:0] h;
    ang_t r;
    h     = (a >= 14'(HALF_TURN)) ? 13'(a - 14'(HALF_TURN)) : a[12:0];
    r.neg = (a >= 14'(HALF_TURN));
    r.q   = (h <= 13'(QUARTER)) ? h[10:0] : 11'(13'(HALF_TURN) - h);
    return r;
  endfunction

  logic [12:0]       yaw_m;
  logic [13:0]       cos_a;
  logic signed [11:0] pc;
  logic [11:0]       pneg;
  ang_t              ang [3];

  always_comb begin
    yaw_m = (a_d.yaw >= 13'(FULL_TURN)) ? 13'(a_d.yaw - 13'(FULL_TURN)) : a_d.yaw;
    cos_a = 14'(yaw_m) + 14'(QUARTER);
    if (cos_a >= 14'(FULL_TURN)) cos_a = cos_a - 14'(FULL_TURN);
    pc = a_d.pitch;
    if (pc > 12'sd1440)  pc = 12'sd1440;
    if (pc < -12'sd1440) pc = -12'sd1440;
    pneg   = 12'(-pc);
    ang[0] = map_angle(cos_a);
    ang[1] = map_angle(14'(yaw_m));
    if (pc < 0) begin
      ang[2].q   = pneg[10:0];
      ang[2].neg = 1'b1;
    end else begin
      ang[2].q   = pc[10:0];
      ang[2].neg = 1'b0;
    end
  end

  // ---------------- stage B: sine ROM read ----------------
  // Two ROM copies: one serves the cosine and sine of yaw, one the pitch.
  localparam sine_tab_t ROM_YAW   = SINE_TAB;
  localparam sine_tab_t ROM_PITCH = SINE_TAB;

  logic             b_v;
  logic [MAG_W-1:0] b_mag [3];
  logic             b_neg [3];
  logic [POS_W-1:0] b_pos [3];

  always_ff @(posedge clk) begin
    if (rst)      b_v <= 1'b0;
    else if (adv) b_v <= a_v;
    if (adv) begin
      b_mag[0] <= ROM_YAW[ang[0].q];
      b_mag[1] <= ROM_YAW[ang[1].q];
      b_mag[2] <= ROM_PITCH[ang[2].q];
      for (int i = 0; i < 3; i++) b_neg[i] <= ang[i].neg;
      b_pos[0] <= a_d.pos_x;
      b_pos[1] <= a_d.pos_y;
      b_pos[2] <= a_d.pos_z;
    end
  end

  // ---------------- remainder dividers: whole part mod cell ----------------
  logic             d1_v;
  logic [INT_W-1:0] d1_rem  [3];
  logic [S1_W-1:0]  d1_side [3];

  for (genvar g = 0; g < 3; g++) begin : g_rem
    if (g == 0) begin : g_lead
      grb_div #(.NW(INT_W), .DW(CELL_W), .QW(INT_W), .SW(S1_W)) u_div (
        .clk, .rst, .en(adv), .in_valid(b_v),
        .num(b_pos[g][POS_W-1:POS_FRAC_BITS]), .den(cell_eff),
        .side_in({b_mag[g], b_neg[g], b_pos[g]}),
        .out_valid(d1_v), .quo(), .rem_out(d1_rem[g]), .side_out(d1_side[g])
      );
    end else begin : g_lane
      grb_div #(.NW(INT_W), .DW(CELL_W), .QW(INT_W), .SW(S1_W)) u_div (
        .clk, .rst, .en(adv), .in_valid(b_v),
        .num(b_pos[g][POS_W-1:POS_FRAC_BITS]), .den(cell_eff),
        .side_in({b_mag[g], b_neg[g], b_pos[g]}),
        .out_valid(), .quo(), .rem_out(d1_rem[g]), .side_out(d1_side[g])
      );
    end
  end

  // ---------------- stage C: distance to the plane ----------------
  logic [CQ_W-1:0]  cq;
  logic [CQ_W-1:0]  rem_full [3];
  logic [CQ_W-1:0]  dist_c   [3];
  logic             c_v;
  logic [CQ_W-1:0]  c_dist [3];
  logic [MAG_W-1:0] c_mag  [3];
  logic             c_neg  [3];
  logic [POS_W-1:0] c_pos  [3];

  assign cq = CQ_W'(cell_eff) << POS_FRAC_BITS;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_full[i] = (CQ_W'(d1_rem[i]) << POS_FRAC_BITS)
                  | CQ_W'(d1_side[i][POS_FRAC_BITS-1:0]);
      if (d1_side[i][POS_W])  // moving down: on a plane means one full cell
        dist_c[i] = (rem_full[i] != '0) ? rem_full[i] : cq;
      else
        dist_c[i] = cq - rem_full[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)      c_v <= 1'b0;
    else if (adv) c_v <= d1_v;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_dist[i] <= dist_c[i];
        c_mag[i]  <= d1_side[i][S1_W-1:POS_W+1];
        c_neg[i]  <= d1_side[i][POS_W];
        c_pos[i]  <= d1_side[i][POS_W-1:0];
      end
    end
  end

  // ---------------- stage D: cross products ----------------
  logic              d_v;
  logic [PROD_W-1:0] p01, p10, p02, p20, p12, p21;
  logic [CQ_W-1:0]   d_dist [3];
  logic [MAG_W-1:0]  d_mag  [3];
  logic              d_neg  [3];
  logic [POS_W-1:0]  d_pos  [3];

  always_ff @(posedge clk) begin
    if (rst)      d_v <= 1'b0;
    else if (adv) d_v <= c_v;
    if (adv) begin
      p01 <= PROD_W'(c_dist[0]) * PROD_W'(c_mag[1]);
      p10 <= PROD_W'(c_dist[1]) * PROD_W'(c_mag[0]);
      p02 <= PROD_W'(c_dist[0]) * PROD_W'(c_mag[2]);
      p20 <= PROD_W'(c_dist[2]) * PROD_W'(c_mag[0]);
      p12 <= PROD_W'(c_dist[1]) * PROD_W'(c_mag[2]);
      p21 <= PROD_W'(c_dist[2]) * PROD_W'(c_mag[1]);
      d_dist <= c_dist;
      d_mag  <= c_mag;
      d_neg  <= c_neg;
      d_pos  <= c_pos;
    end
  end

  // ---------------- stage E: nearest plane, ties to the lower axis ----------
  logic             nz [3];
  logic             has1, hasb;
  logic [1:0]       b1, bsel;
  logic             z_wins;
  logic [CQ_W-1:0]  bd_e;
  logic [MAG_W-1:0] bm_e;

  always_comb begin
    for (int i = 0; i < 3; i++) nz[i] = (d_mag[i] != '0);
    has1 = nz[0] || nz[1];
    if (nz[0] && !(nz[1] && (p10 < p01))) b1 = AXIS_X;
    else                                  b1 = AXIS_Y;
    z_wins = nz[2] && (!has1 || ((b1 == AXIS_X) ? (p20 < p02) : (p21 < p12)));
    bsel   = z_wins ? AXIS_Z : b1;
    hasb   = has1 || nz[2];
    if (!hasb) begin   // no usable axis: zero step
      bsel = AXIS_X;
      bd_e = '0;
      bm_e = MAG_W'(1);
    end else begin
      bd_e = d_dist[bsel];
      bm_e = d_mag[bsel];
    end
  end

  logic             e_v;
  logic [1:0]       e_axis;
  logic [CQ_W-1:0]  e_bd;
  logic [MAG_W-1:0] e_bm;
  logic [MAG_W-1:0] e_mag [3];
  logic             e_neg [3];
  logic [POS_W-1:0] e_pos [3];

  always_ff @(posedge clk) begin
    if (rst)      e_v <= 1'b0;
    else if (adv) e_v <= d_v;
    if (adv) begin
      e_axis <= bsel;
      e_bd   <= bd_e;
      e_bm   <= bm_e;
      e_mag  <= d_mag;
      e_neg  <= d_neg;
      e_pos  <= d_pos;
    end
  end

  // ---------------- stage F: offset numerators ----------------
  // The winning axis goes through the same formula and comes out as its
  // own distance exactly.
  logic             f_v;
  logic [NUM_W-1:0] f_num [3];
  logic [MAG_W-1:0] f_bm;
  logic [1:0]       f_axis;
  logic             f_neg [3];
  logic [POS_W-1:0] f_pos [3];

  always_ff @(posedge clk) begin
    if (rst)      f_v <= 1'b0;
    else if (adv) f_v <= e_v;
    if (adv) begin
      for (int i = 0; i < 3; i++)
        f_num[i] <= NUM_W'(e_mag[i]) * NUM_W'(e_bd) + NUM_W'(e_bm >> 1);
      f_bm   <= e_bm;
      f_axis <= e_axis;
      f_neg  <= e_neg;
      f_pos  <= e_pos;
    end
  end

  // ---------------- offset dividers ----------------
  // A quotient that does not fit saturates; such a coordinate leaves the range.
  localparam int CMP_W = NUM_W + OFF_W;

  logic             ovf [3];
  logic             d2_v;
  logic [OFF_W-1:0] d2_q    [3];
  logic [S2_W-1:0]  d2_side [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      ovf[i] = CMP_W'(f_num[i]) >= (CMP_W'(f_bm) << OFF_W);
  end

  for (genvar g = 0; g < 3; g++) begin : g_off
    if (g == 0) begin : g_lead
      grb_div #(.NW(NUM_W), .DW(MAG_W), .QW(OFF_W), .SW(S2_W)) u_div (
        .clk, .rst, .en(adv), .in_valid(f_v),
        .num(f_num[g]), .den(f_bm),
        .side_in({f_axis, ovf[g], f_neg[g], f_pos[g]}),
        .out_valid(d2_v), .quo(d2_q[g]), .rem_out(), .side_out(d2_side[g])
      );
    end else begin : g_lane
      grb_div #(.NW(NUM_W), .DW(MAG_W), .QW(OFF_W), .SW(S2_W)) u_div (
        .clk, .rst, .en(adv), .in_valid(f_v),
        .num(f_num[g]), .den(f_bm),
        .side_in({f_axis, ovf[g], f_neg[g], f_pos[g]}),
        .out_valid(), .quo(d2_q[g]), .rem_out(), .side_out(d2_side[g])
      );
    end
  end

  // ---------------- output stage: apply, test, saturate ----------------
  logic [OFF_W-1:0]       off  [3];
  logic signed [NC_W-1:0] nc   [3];
  logic [POS_W-1:0]       sat  [3];
  logic signed [NC_W-1:0] lim;
  logic                   in_world;

  always_comb begin
    lim      = NC_W'(world_limit) << POS_FRAC_BITS;
    in_world = 1'b1;
    for (int i = 0; i < 3; i++) begin
      off[i] = d2_side[i][POS_W+1] ? {OFF_W{1'b1}} : d2_q[i];
      if (d2_side[i][POS_W])
        nc[i] = $signed(NC_W'(d2_side[i][POS_W-1:0])) - $signed(NC_W'(off[i]));
      else
        nc[i] = $signed(NC_W'(d2_side[i][POS_W-1:0])) + $signed(NC_W'(off[i]));
      if (!(nc[i] > 0 && nc[i] < lim)) in_world = 1'b0;
      if (nc[i] < 0)
        sat[i] = '0;
      else if (nc[i] > $signed(NC_W'({POS_W{1'b1}})))
        sat[i] = {POS_W{1'b1}};
      else
        sat[i] = nc[i][POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)      out_valid <= 1'b0;
    else if (adv) out_valid <= d2_v;
    if (adv) begin
      out_data.next_x       <= sat[0];
      out_data.next_y       <= sat[1];
      out_data.next_z       <= sat[2];
      out_data.crossed_axis <= d2_side[0][S2_W-1:S2_W-2];
      out_data.inside_world <= in_world;
    end
  end

  // ---------------- assertions ----------------
  a_axis_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.crossed_axis != 2'd3)
    else $error("crossed_axis out of range");

  a_inside_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.inside_world |->
      out_data.next_x != '0 && out_data.next_y != '0 && out_data.next_z != '0)
    else $error("inside_world with a zero coordinate");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(a_v) && $stable(e_v) && $stable(f_v))
    else $error("pipeline moved during a stall");

endmodule
